### rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants for the positional list buffer
// sizes, command and status codes, cell control word and data helpers
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int RDV_W   = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int S_DATA_W = 8 * ((CMD_W + VALUE_W + POS_W + 7) / 8);
    localparam int M_DATA_W = 8 * ((RDV_W + COUNT_W + STAT_W + 7) / 8);

    // occupancy counter, cell index and compare widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_POP_BACK   = 3'd5,
        CMD_READ       = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_REMOVE = 2'd2
    } shift_op_t;

    // control word broadcast to every cell
    typedef struct packed {
        shift_op_t          op;
        logic [CMP_W-1:0]   pos;
    } shift_ctl_t;

    typedef logic [DATA_WIDTH-1:0] data_t;

    // input value to stored word: keep the low DATA_WIDTH bits, zero above
    function automatic data_t to_data(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] t;
        t = {{DATA_WIDTH{1'b0}}, v};
        return t[DATA_WIDTH-1:0];
    endfunction

    // stored word to read field: low bits, zero above
    function automatic logic [RDV_W-1:0] from_data(input data_t d);
        logic [DATA_WIDTH+RDV_W-1:0] t;
        t = {{RDV_W{1'b0}}, d};
        return t[RDV_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] t;
        t = {{COUNT_W{1'b0}}, c};
        return t[COUNT_W-1:0];
    endfunction

endpackage

### rtl/plb_cell.sv
// ----------------------------------------------------------------------------
// plb_cell: one slot of the list
// holds one word; on insert takes its left neighbor or the new value,
// on remove takes its right neighbor
// ----------------------------------------------------------------------------
module plb_cell (
    input  logic                        aclk,
    input  plb_pkg::shift_ctl_t         ctl,
    input  logic [plb_pkg::CMP_W-1:0]   cell_index,
    input  plb_pkg::data_t              new_value,
    input  plb_pkg::data_t              left_data,
    input  plb_pkg::data_t              right_data,
    output plb_pkg::data_t              data_out
);
    import plb_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            SHIFT_INSERT: begin
                if (cell_index > ctl.pos) begin
                    data_next = left_data;
                end else if (cell_index == ctl.pos) begin
                    data_next = new_value;
                end
            end
            SHIFT_REMOVE: begin
                if (cell_index >= ctl.pos) begin
                    data_next = right_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### rtl/positional_list_buffer.sv
// ----------------------------------------------------------------------------
// positional_list_buffer: ordered list with positional insert and remove
// a row of cells shifts together; a registered result per command
// ----------------------------------------------------------------------------
// Each command completes at once: all cells at or behind the target
// position shift toward their neighbor on the same edge, so push, insert,
// remove, pop, read and clear all complete together and the result word
// appears on the master side in the cycle after the command word is taken.
// The result sits in an output register; s_tready stays high while that
// register is empty or being drained, so back-to-back commands run at one
// word per cycle when the sink keeps m_tready high. Reads pick the addressed
// cell through one wide select. Out-of-range positions and pops on an empty
// list leave the list as is with status bad; pushes and inserts on a full
// list are dropped with status full. Clear only resets the count.
// ----------------------------------------------------------------------------
module positional_list_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command word: command [2:0], value [34:3], position [39:35]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plb_pkg::S_DATA_W-1:0]    s_tdata,
    // result word: read_value [31:0], count [36:32], status [38:37], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plb_pkg::M_DATA_W-1:0]    m_tdata
);
    import plb_pkg::*;

    // unpacked command fields
    cmd_t                   s_command;
    logic [VALUE_W-1:0]     s_value;
    logic [POS_W-1:0]       s_position;

    assign s_command  = cmd_t'(s_tdata[CMD_W-1:0]);
    assign s_value    = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign s_position = s_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];

    logic s_accept;
    assign s_tready = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // element count
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] pos_ext;
    assign occ_ext = CMP_W'(occ_reg);
    assign pos_ext = CMP_W'(s_position);

    // cell row
    data_t      cell_data [CAPACITY];
    shift_ctl_t cell_ctl;
    data_t      new_word;
    assign new_word = to_data(s_value);

    // decoded command
    logic               is_ins;
    logic               is_rem;
    logic [CMP_W-1:0]   target;
    status_t            status_c;
    logic [RDV_W-1:0]   read_c;

    always_comb begin
        is_ins       = 1'b0;
        is_rem       = 1'b0;
        target       = '0;
        status_c     = ST_DONE;
        read_c       = '0;
        occ_next     = occ_reg;
        cell_ctl.op  = SHIFT_HOLD;
        cell_ctl.pos = '0;

        case (s_command)
            CMD_PUSH_FRONT: begin
                is_ins = 1'b1;
            end
            CMD_PUSH_BACK: begin
                is_ins = 1'b1;
                target = occ_ext;
            end
            CMD_INSERT: begin
                is_ins = 1'b1;
                target = pos_ext;
            end
            CMD_REMOVE: begin
                is_rem = 1'b1;
                target = pos_ext;
            end
            CMD_POP_FRONT: begin
                is_rem = 1'b1;
            end
            CMD_POP_BACK: begin
                // on an empty list this wraps high and fails the range check
                is_rem = 1'b1;
                target = occ_ext - CMP_W'(1);
            end
            CMD_READ: begin
                if (pos_ext < occ_ext) begin
                    read_c = from_data(cell_data[IDX_W'(s_position)]);
                end else begin
                    status_c = ST_BAD;
                end
            end
            CMD_CLEAR: begin
                occ_next = '0;
            end
            default: ;
        endcase

        if (is_ins) begin
            if (target > occ_ext) begin
                status_c = ST_BAD;
            end else if (occ_reg == CNT_W'(CAPACITY)) begin
                status_c = ST_FULL;
            end else begin
                cell_ctl.op = SHIFT_INSERT;
                occ_next    = occ_reg + CNT_W'(1);
            end
        end

        if (is_rem) begin
            if (target >= occ_ext) begin
                status_c = ST_BAD;
            end else begin
                cell_ctl.op = SHIFT_REMOVE;
                occ_next    = occ_reg - CNT_W'(1);
            end
        end

        cell_ctl.pos = target;

        // nothing moves unless the command word is actually taken
        if (!s_accept) begin
            cell_ctl.op = SHIFT_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            data_t left_d;
            data_t right_d;
            if (gi == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_inner_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_inner_r
                assign right_d = cell_data[gi+1];
            end

            plb_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl),
                .cell_index (CMP_W'(gi)),
                .new_value  (new_word),
                .left_data  (left_d),
                .right_data (right_d),
                .data_out   (cell_data[gi])
            );
        end
    endgenerate

    // count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (s_accept) begin
            occ_reg <= occ_next;
        end
    end

    // output register
    logic                   m_valid_reg;
    logic [M_DATA_W-1:0]    m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= M_DATA_W'({status_c, to_count(occ_next), read_c});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/plb_checker.sv
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the positional list buffer
// watches the command and result streams, bound to the top level
// ----------------------------------------------------------------------------
module plb_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [plb_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [plb_pkg::M_DATA_W-1:0]    m_tdata
);
    import plb_pkg::*;

    logic [RDV_W-1:0]   chk_read;
    logic [COUNT_W-1:0] chk_count;
    logic [STAT_W-1:0]  chk_status;
    assign chk_read   = m_tdata[RDV_W-1:0];
    assign chk_count  = m_tdata[RDV_W+COUNT_W-1:RDV_W];
    assign chk_status = m_tdata[RDV_W+COUNT_W+STAT_W-1:RDV_W+COUNT_W];

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every taken command gives a result word in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("command without result");

    // clear always succeeds and empties the list
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[CMD_W-1:0] == CMD_CLEAR
        |=> chk_count == '0 && chk_status == ST_DONE)
        else $error("clear did not empty the list");

    // failed commands carry a zero read field and a known status
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status != ST_DONE
        |-> chk_read == '0 && (chk_status == ST_BAD || chk_status == ST_FULL))
        else $error("bad status or nonzero read field");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (.*);
